// File: rtl/cscan_pkg.sv
// ----------------------------------------------------------------------------
// cscan_pkg
// Shared types, codes and sizes for the two group box collision scan unit.
// ----------------------------------------------------------------------------
package cscan_pkg;

	// default table depths
	localparam int PLAYER_SLOTS_DEF = 4;
	localparam int ENEMY_SLOTS_DEF  = 16;

	// most pair words reported for one tick
	localparam int MAX_OUT = 64;
	localparam int CNT_W   = $clog2(MAX_OUT + 1);

	// stream widths
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 40;

	// operation codes
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_MOVE   = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	// object kinds that matter to the logic
	localparam logic [2:0] KIND_UNKNOWN     = 3'd0;
	localparam logic [2:0] KIND_PLAYER_FIRE = 3'd2;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_DUP       = 3'd3;
	localparam logic [2:0] ST_BAD_ARG   = 3'd4;

	// hit event codes
	localparam logic [1:0] HIT_NONE   = 2'd0;
	localparam logic [1:0] HIT_ENEMY  = 2'd1;
	localparam logic [1:0] HIT_PLAYER = 2'd2;

	// one stored object
	typedef struct packed {
		logic [7:0]  size;
		logic [11:0] y;
		logic [11:0] x;
		logic [15:0] id;
	} obj_t;

	// player side entry carries the fire flag on top
	typedef struct packed {
		logic fire;
		obj_t obj;
	} pl_entry_t;

	// input word as packed in tdata, highest field first
	typedef struct packed {
		logic [7:0]  obj_size;
		logic [11:0] pos_y;
		logic [11:0] pos_x;
		logic [2:0]  kind;
		logic [15:0] entity_id;
	} in_word_t;

endpackage

// File: rtl/cscan_ram.sv
// ----------------------------------------------------------------------------
// cscan_ram
// Simple dual port synchronous memory, one write and one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module cscan_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data holds between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/cscan_cmp.sv
// ----------------------------------------------------------------------------
// cscan_cmp
// Box overlap test of one player object against one enemy object: both axis
// distances must be within the larger of the two half extents.
// ----------------------------------------------------------------------------
module cscan_cmp (
	input  cscan_pkg::obj_t a,
	input  cscan_pkg::obj_t b,
	output logic            hit
);

	logic [7:0]  lim;
	logic [11:0] dx;
	logic [11:0] dy;

	// larger half extent
	assign lim = (a.size > b.size) ? a.size : b.size;

	// absolute axis distances
	assign dx = (a.x >= b.x) ? (a.x - b.x) : (b.x - a.x);
	assign dy = (a.y >= b.y) ? (a.y - b.y) : (b.y - a.y);

	assign hit = (dx <= {4'd0, lim}) && (dy <= {4'd0, lim});

endmodule

// File: rtl/two_group_box_collision_scan_unit.sv
// Add, remove and move search the player table then the enemy table by id,
// reading each valid entry and skipping free slots, then update and answer.
// Tick: each valid player slot is read, then each valid enemy slot is read and compared;
// a pair word waits in the output register while the sink stalls.
// One word in at a time; the serial walks over the two tables set the pace.
// Reset clears the valid bits at once; table contents need no clearing pass.
// ----------------------------------------------------------------------------
// two_group_box_collision_scan_unit
// Player and enemy object tables in synchronous memories with add, remove and
// move by id, and a tick that reports the overlapping pairs in slot order, at most MAX_OUT of them.
// ----------------------------------------------------------------------------
module two_group_box_collision_scan_unit #(
	parameter int PLAYER_SLOTS = cscan_pkg::PLAYER_SLOTS_DEF,
	parameter int ENEMY_SLOTS  = cscan_pkg::ENEMY_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// entity_id[15:0], kind[18:16], pos_x[30:19], pos_y[42:31], obj_size[50:43]
	input  logic [cscan_pkg::IN_DATA_W-1:0]  s_tdata,
	// op[1:0]
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status[2:0], player_obj_id[18:3], enemy_obj_id[34:19]
	output logic [cscan_pkg::OUT_DATA_W-1:0] m_tdata,
	// hit_event[1:0]
	output logic [1:0]                       m_tuser,
	output logic                             m_tlast
);

	localparam int PI_W = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;
	localparam int EI_W = (ENEMY_SLOTS > 1) ? $clog2(ENEMY_SLOTS) : 1;
	localparam logic [PI_W-1:0] P_LAST = PI_W'(PLAYER_SLOTS - 1);
	localparam logic [EI_W-1:0] E_LAST = EI_W'(ENEMY_SLOTS - 1);
	localparam int PL_W = $bits(cscan_pkg::pl_entry_t);
	localparam int EN_W = $bits(cscan_pkg::obj_t);

	typedef enum logic [3:0] {
		IDLE,
		F_PRD,
		F_PCMP,
		F_ERD,
		F_ECMP,
		F_DONE,
		RESP,
		T_PRD,
		T_ERD,
		T_ECMP,
		T_FLUSH
	} state_t;

	state_t st_q;

	// captured input word
	cscan_pkg::op_t op_q;
	logic [15:0]    id_q;
	logic [2:0]     kind_q;
	logic [11:0]    x_q;
	logic [11:0]    y_q;
	logic [7:0]     sz_q;

	// scan control
	logic [PI_W-1:0]              pidx_q;
	logic [EI_W-1:0]              eidx_q;
	logic [PLAYER_SLOTS-1:0]      p_vld_q;
	logic [ENEMY_SLOTS-1:0]       e_vld_q;
	logic                         found_q;
	logic                         fnd_pl_q;
	logic [2:0]                   status_q;
	logic [cscan_pkg::CNT_W-1:0]  cnt_q;

	// pending pair, held back until its last flag is known
	logic        pend_q;
	logic [1:0]  pend_ev_q;
	logic [15:0] pend_pid_q;
	logic [15:0] pend_eid_q;

	// output register
	logic        m_tvalid_q;
	logic        m_tlast_q;
	logic [2:0]  out_st_q;
	logic [1:0]  out_ev_q;
	logic [15:0] out_pid_q;
	logic [15:0] out_eid_q;

	cscan_pkg::in_word_t  in_w;
	cscan_pkg::pl_entry_t p_rd;
	cscan_pkg::obj_t      e_rd;
	cscan_pkg::pl_entry_t p_wr_data;
	cscan_pkg::obj_t      e_wr_data;
	logic                 p_rd_en;
	logic                 e_rd_en;
	logic                 p_wr_en;
	logic                 e_wr_en;
	logic [PI_W-1:0]      p_wr_addr;
	logic [EI_W-1:0]      e_wr_addr;
	logic [PI_W-1:0]      p_free;
	logic [EI_W-1:0]      e_free;
	logic                 p_free_ok;
	logic                 e_free_ok;
	logic                 to_pl;
	logic                 add_ok;
	logic [2:0]           done_st;
	logic                 pair_hit;
	logic                 out_free;
	logic                 out_load;
	logic                 p_end;
	logic                 e_end;
	logic                 pl_id_eq;
	logic                 en_id_eq;

	assign in_w     = cscan_pkg::in_word_t'(s_tdata[$bits(cscan_pkg::in_word_t)-1:0]);
	assign out_free = !m_tvalid_q || m_tready;
	assign p_end    = (pidx_q == P_LAST);
	assign e_end    = (eidx_q == E_LAST);
	assign pl_id_eq = (p_rd.obj.id == id_q);
	assign en_id_eq = (e_rd.id == id_q);
	assign to_pl    = (kind_q <= cscan_pkg::KIND_PLAYER_FIRE);

	// output register takes a new word this cycle
	assign out_load = out_free && ((st_q == RESP) || (st_q == T_FLUSH) ||
		((st_q == T_ECMP) && pair_hit && pend_q));

	// lowest free slot of each table
	always_comb begin
		p_free    = '0;
		p_free_ok = 1'b0;
		for (int i = PLAYER_SLOTS - 1; i >= 0; i--) begin
			if (!p_vld_q[i]) begin
				p_free    = PI_W'(i);
				p_free_ok = 1'b1;
			end
		end
	end

	always_comb begin
		e_free    = '0;
		e_free_ok = 1'b0;
		for (int i = ENEMY_SLOTS - 1; i >= 0; i--) begin
			if (!e_vld_q[i]) begin
				e_free    = EI_W'(i);
				e_free_ok = 1'b1;
			end
		end
	end

	// update decision once the id search is over
	always_comb begin
		add_ok  = (op_q == cscan_pkg::OP_ADD) && !found_q && (to_pl ? p_free_ok : e_free_ok);
		done_st = cscan_pkg::ST_OK;
		if (op_q == cscan_pkg::OP_ADD) begin
			if (found_q) begin
				done_st = cscan_pkg::ST_DUP;
			end else if (!add_ok) begin
				done_st = cscan_pkg::ST_FULL;
			end
		end else if (!found_q) begin
			done_st = cscan_pkg::ST_NOT_FOUND;
		end
	end

	// memory strobes: reads while scanning, read-modify-write on update
	always_comb begin
		p_rd_en   = ((st_q == F_PRD) || (st_q == T_PRD)) && p_vld_q[pidx_q];
		e_rd_en   = ((st_q == F_ERD) || (st_q == T_ERD)) && e_vld_q[eidx_q];
		p_wr_en   = (st_q == F_DONE) && ((add_ok && to_pl) ||
			((op_q == cscan_pkg::OP_MOVE) && found_q && fnd_pl_q));
		e_wr_en   = (st_q == F_DONE) && ((add_ok && !to_pl) ||
			((op_q == cscan_pkg::OP_MOVE) && found_q && !fnd_pl_q));
		p_wr_addr = (op_q == cscan_pkg::OP_ADD) ? p_free : pidx_q;
		e_wr_addr = (op_q == cscan_pkg::OP_ADD) ? e_free : eidx_q;
		if (op_q == cscan_pkg::OP_ADD) begin
			p_wr_data.fire     = (kind_q == cscan_pkg::KIND_PLAYER_FIRE);
			p_wr_data.obj.size = sz_q;
			e_wr_data.size     = sz_q;
			p_wr_data.obj.id   = id_q;
			e_wr_data.id       = id_q;
		end else begin
			p_wr_data.fire     = p_rd.fire;
			p_wr_data.obj.size = p_rd.obj.size;
			e_wr_data.size     = e_rd.size;
			p_wr_data.obj.id   = p_rd.obj.id;
			e_wr_data.id       = e_rd.id;
		end
		p_wr_data.obj.x = x_q;
		p_wr_data.obj.y = y_q;
		e_wr_data.x     = x_q;
		e_wr_data.y     = y_q;
	end

	cscan_ram #(
		.WIDTH (PL_W),
		.DEPTH (PLAYER_SLOTS),
		.AW    (PI_W)
	) u_pl_ram (
		.clk     (clk),
		.wr_en   (p_wr_en),
		.wr_addr (p_wr_addr),
		.wr_data (p_wr_data),
		.rd_en   (p_rd_en),
		.rd_addr (pidx_q),
		.rd_data (p_rd)
	);

	cscan_ram #(
		.WIDTH (EN_W),
		.DEPTH (ENEMY_SLOTS),
		.AW    (EI_W)
	) u_en_ram (
		.clk     (clk),
		.wr_en   (e_wr_en),
		.wr_addr (e_wr_addr),
		.wr_data (e_wr_data),
		.rd_en   (e_rd_en),
		.rd_addr (eidx_q),
		.rd_data (e_rd)
	);

	// overlap of held player entry and freshly read enemy entry
	cscan_cmp u_cmp (
		.a   (p_rd.obj),
		.b   (e_rd),
		.hit (pair_hit)
	);

	// input word capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= cscan_pkg::op_t'(s_tuser);
			id_q   <= in_w.entity_id;
			kind_q <= in_w.kind;
			x_q    <= in_w.pos_x;
			y_q    <= in_w.pos_y;
			sz_q   <= in_w.obj_size;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= IDLE;
			pidx_q     <= '0;
			eidx_q     <= '0;
			p_vld_q    <= '0;
			e_vld_q    <= '0;
			found_q    <= 1'b0;
			fnd_pl_q   <= 1'b0;
			status_q   <= cscan_pkg::ST_OK;
			cnt_q      <= '0;
			pend_q     <= 1'b0;
			pend_ev_q  <= cscan_pkg::HIT_NONE;
			pend_pid_q <= '0;
			pend_eid_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
			out_st_q   <= cscan_pkg::ST_OK;
			out_ev_q   <= cscan_pkg::HIT_NONE;
			out_pid_q  <= '0;
			out_eid_q  <= '0;
		end else begin
			if (m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (st_q)
				IDLE: begin
					pidx_q  <= '0;
					eidx_q  <= '0;
					found_q <= 1'b0;
					cnt_q   <= '0;
					pend_q  <= 1'b0;
					if (s_tvalid) begin
						if (cscan_pkg::op_t'(s_tuser) == cscan_pkg::OP_TICK) begin
							st_q <= T_PRD;
						end else if ((cscan_pkg::op_t'(s_tuser) == cscan_pkg::OP_ADD) &&
							((in_w.entity_id == 16'd0) ||
							(in_w.kind == cscan_pkg::KIND_UNKNOWN))) begin
							status_q <= cscan_pkg::ST_BAD_ARG;
							st_q     <= RESP;
						end else begin
							st_q <= F_PRD;
						end
					end
				end
				// id search over the player table
				F_PRD: begin
					if (p_vld_q[pidx_q]) begin
						st_q <= F_PCMP;
					end else if (p_end) begin
						st_q <= F_ERD;
					end else begin
						pidx_q <= pidx_q + PI_W'(1);
					end
				end
				F_PCMP: begin
					if (pl_id_eq) begin
						found_q  <= 1'b1;
						fnd_pl_q <= 1'b1;
						st_q     <= F_DONE;
					end else if (p_end) begin
						st_q <= F_ERD;
					end else begin
						pidx_q <= pidx_q + PI_W'(1);
						st_q   <= F_PRD;
					end
				end
				// id search over the enemy table
				F_ERD: begin
					if (e_vld_q[eidx_q]) begin
						st_q <= F_ECMP;
					end else if (e_end) begin
						st_q <= F_DONE;
					end else begin
						eidx_q <= eidx_q + EI_W'(1);
					end
				end
				F_ECMP: begin
					if (en_id_eq) begin
						found_q  <= 1'b1;
						fnd_pl_q <= 1'b0;
						st_q     <= F_DONE;
					end else if (e_end) begin
						st_q <= F_DONE;
					end else begin
						eidx_q <= eidx_q + EI_W'(1);
						st_q   <= F_ERD;
					end
				end
				// table write and valid bit update happen here
				F_DONE: begin
					status_q <= done_st;
					if (add_ok && to_pl) begin
						p_vld_q[p_free] <= 1'b1;
					end
					if (add_ok && !to_pl) begin
						e_vld_q[e_free] <= 1'b1;
					end
					if ((op_q == cscan_pkg::OP_REMOVE) && found_q) begin
						if (fnd_pl_q) begin
							p_vld_q[pidx_q] <= 1'b0;
						end else begin
							e_vld_q[eidx_q] <= 1'b0;
						end
					end
					st_q <= RESP;
				end
				RESP: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tlast_q  <= 1'b1;
						out_st_q   <= status_q;
						out_ev_q   <= cscan_pkg::HIT_NONE;
						out_pid_q  <= '0;
						out_eid_q  <= '0;
						st_q       <= IDLE;
					end
				end
				// tick: fetch one player entry, it stays on the read port
				T_PRD: begin
					eidx_q <= '0;
					if (p_vld_q[pidx_q]) begin
						st_q <= T_ERD;
					end else if (p_end) begin
						st_q <= T_FLUSH;
					end else begin
						pidx_q <= pidx_q + PI_W'(1);
					end
				end
				T_ERD: begin
					if (e_vld_q[eidx_q]) begin
						st_q <= T_ECMP;
					end else if (!e_end) begin
						eidx_q <= eidx_q + EI_W'(1);
					end else if (!p_end) begin
						pidx_q <= pidx_q + PI_W'(1);
						st_q   <= T_PRD;
					end else begin
						st_q <= T_FLUSH;
					end
				end
				// compare; a new hit pushes the pending one out
				T_ECMP: begin
					if (pair_hit && pend_q && !out_free) begin
						st_q <= T_ECMP;
					end else begin
						if (pair_hit) begin
							if (pend_q) begin
								m_tvalid_q <= 1'b1;
								m_tlast_q  <= 1'b0;
								out_st_q   <= cscan_pkg::ST_OK;
								out_ev_q   <= pend_ev_q;
								out_pid_q  <= pend_pid_q;
								out_eid_q  <= pend_eid_q;
							end
							pend_q     <= 1'b1;
							pend_ev_q  <= p_rd.fire ? cscan_pkg::HIT_ENEMY : cscan_pkg::HIT_PLAYER;
							pend_pid_q <= p_rd.obj.id;
							pend_eid_q <= e_rd.id;
							cnt_q      <= cnt_q + cscan_pkg::CNT_W'(1);
						end
						if (pair_hit && (cnt_q == cscan_pkg::CNT_W'(cscan_pkg::MAX_OUT - 1))) begin
							st_q <= T_FLUSH;
						end else if (!e_end) begin
							eidx_q <= eidx_q + EI_W'(1);
							st_q   <= T_ERD;
						end else if (!p_end) begin
							pidx_q <= pidx_q + PI_W'(1);
							st_q   <= T_PRD;
						end else begin
							st_q <= T_FLUSH;
						end
					end
				end
				// final word of the tick
				T_FLUSH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tlast_q  <= 1'b1;
						out_st_q   <= cscan_pkg::ST_OK;
						out_ev_q   <= pend_q ? pend_ev_q : cscan_pkg::HIT_NONE;
						out_pid_q  <= pend_q ? pend_pid_q : 16'd0;
						out_eid_q  <= pend_q ? pend_eid_q : 16'd0;
						pend_q     <= 1'b0;
						st_q       <= IDLE;
					end
				end
				default: begin
					st_q <= IDLE;
				end
			endcase
		end
	end

	// port drive
	assign s_tready = (st_q == IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = out_ev_q;
	assign m_tdata  = {{(cscan_pkg::OUT_DATA_W - 35){1'b0}}, out_eid_q, out_pid_q, out_st_q};

endmodule

// File: rtl/cscan_chk.sv
// ----------------------------------------------------------------------------
// cscan_chk
// Port level checks of the collision scan unit, bound to the top level.
// ----------------------------------------------------------------------------
module cscan_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [cscan_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic [1:0]                       s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [cscan_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]                       m_tuser,
	input logic                             m_tlast
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result word changed while stalled");

	// one word at a time: no new word right after one is taken in
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while the previous one is in work");

	// collision reports always carry ok status
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != cscan_pkg::HIT_NONE) |-> m_tdata[2:0] == cscan_pkg::ST_OK)
		else $error("collision report with error status");

	// only collision reports may be followed by more words
	a_nonlast_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tuser == cscan_pkg::HIT_ENEMY) ||
		(m_tuser == cscan_pkg::HIT_PLAYER))
		else $error("non final word is not a collision");

	// no-collision words carry zero ids
	a_none_ids: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == cscan_pkg::HIT_NONE) |-> m_tdata[34:3] == 32'd0)
		else $error("ids set on a word without collision");

endmodule

bind two_group_box_collision_scan_unit cscan_chk u_cscan_chk (.*);

// File: bench/cscan_checker.sv
// ----------------------------------------------------------------------------
// cscan_checker
// Watches both stream channels of the collision scan unit, keeps its own copy
// of the player and enemy tables, works out the answer words for every
// accepted command word and compares each output word with the oldest one due.
// ----------------------------------------------------------------------------
module cscan_checker
	import cscan_pkg::*;
#(
	parameter int PLAYER_SLOTS = PLAYER_SLOTS_DEF,
	parameter int ENEMY_SLOTS  = ENEMY_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// entity_id[15:0], kind[18:16], pos_x[30:19], pos_y[42:31], obj_size[50:43]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// op[1:0]
	input  logic [1:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// status[2:0], player_obj_id[18:3], enemy_obj_id[34:19]
	input  logic [OUT_DATA_W-1:0] m_tdata,
	// hit_event[1:0]
	input  logic [1:0]            m_tuser,
	input  logic                  m_tlast,
	output int                    fail_count,
	output int                    words_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOTS = PLAYER_SLOTS + ENEMY_SLOTS;

	// one table entry; player slots come first, enemy slots after them
	typedef struct packed {
		logic valid;
		logic fire;
		obj_t obj;
	} slot_t;

	// one answer word as it leaves the block
	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  hit;
		logic [15:0] player_id;
		logic [15:0] enemy_id;
		logic        last;
	} answer_t;

	slot_t   objs [NSLOTS];
	answer_t answers_due [$];
	answer_t got, want;
	int      errors;

	// slot holding an id, player side searched first
	function automatic int locate(logic [15:0] id);
		for (int i = 0; i < NSLOTS; i++)
			if (objs[i].valid && objs[i].obj.id == id)
				return i;
		return -1;
	endfunction

	// lowest free slot in [lo, hi)
	function automatic int first_free(int lo, int hi);
		for (int i = lo; i < hi; i++)
			if (!objs[i].valid)
				return i;
		return -1;
	endfunction

	function automatic int coord_gap(logic [11:0] a, logic [11:0] b);
		return (a >= b) ? int'(a - b) : int'(b - a);
	endfunction

	// apply one command to the table copy and queue the answers it causes
	task automatic model_command(input op_t op, input in_word_t w);
		int      slot;
		int      hits;
		int      reach;
		answer_t r;
		r = '0;
		r.last = 1'b1;
		case (op)
			OP_ADD: begin
				if (w.entity_id == '0 || w.kind == KIND_UNKNOWN) begin
					r.status = ST_BAD_ARG;
				end else if (locate(w.entity_id) >= 0) begin
					r.status = ST_DUP;
				end else begin
					if (w.kind <= KIND_PLAYER_FIRE)
						slot = first_free(0, PLAYER_SLOTS);
					else
						slot = first_free(PLAYER_SLOTS, NSLOTS);
					if (slot < 0) begin
						r.status = ST_FULL;
					end else begin
						objs[slot].valid    = 1'b1;
						objs[slot].fire     = (w.kind == KIND_PLAYER_FIRE);
						objs[slot].obj.id   = w.entity_id;
						objs[slot].obj.x    = w.pos_x;
						objs[slot].obj.y    = w.pos_y;
						objs[slot].obj.size = w.obj_size;
						r.status = ST_OK;
					end
				end
				answers_due = {answers_due, r};
			end
			OP_REMOVE, OP_MOVE: begin
				slot = locate(w.entity_id);
				if (slot < 0) begin
					r.status = ST_NOT_FOUND;
				end else if (op == OP_REMOVE) begin
					objs[slot] = '0;
				end else begin
					objs[slot].obj.x = w.pos_x;
					objs[slot].obj.y = w.pos_y;
				end
				answers_due = {answers_due, r};
			end
			default: begin
				// every player against every enemy, player slot outer
				hits = 0;
				for (int p = 0; p < PLAYER_SLOTS; p++) begin
					if (objs[p].valid) begin
						for (int e = PLAYER_SLOTS; e < NSLOTS; e++) begin
							if (hits < MAX_OUT && objs[e].valid) begin
								reach = (objs[p].obj.size > objs[e].obj.size) ?
									objs[p].obj.size : objs[e].obj.size;
								if (coord_gap(objs[p].obj.x, objs[e].obj.x) <= reach &&
								    coord_gap(objs[p].obj.y, objs[e].obj.y) <= reach) begin
									r.status    = ST_OK;
									r.hit       = objs[p].fire ? HIT_ENEMY : HIT_PLAYER;
									r.player_id = objs[p].obj.id;
									r.enemy_id  = objs[e].obj.id;
									r.last      = 1'b0;
									answers_due = {answers_due, r};
									hits++;
								end
							end
						end
					end
				end
				if (hits == 0)
					answers_due = {answers_due, r};
				else
					answers_due[answers_due.size() - 1].last = 1'b1;
			end
		endcase
	endtask

	// command words feed the model, answer words are checked in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSLOTS; i++)
				objs[i] = '0;
			answers_due.delete();
			errors = 0;
			fail_count = 0;
			words_due <= 0;
		end else begin
			if (s_tvalid && s_tready)
				model_command(op_t'(s_tuser), in_word_t'(s_tdata[$bits(in_word_t)-1:0]));
			if (m_tvalid && m_tready) begin
				got.status    = m_tdata[2:0];
				got.hit       = m_tuser;
				got.player_id = m_tdata[18:3];
				got.enemy_id  = m_tdata[34:19];
				got.last      = m_tlast;
				if (answers_due.size() == 0) begin
					if (errors < 10)
						$display("%t unexpected word: status %0d hit %0d",
							$realtime, got.status, got.hit,
							" player %h enemy %h last %0b",
							got.player_id, got.enemy_id, got.last);
					errors++;
				end else begin
					want = answers_due.pop_front();
					if (got !== want) begin
						if (errors < 10)
							$display("%t word mismatch: expected status %0d hit %0d",
								$realtime, want.status, want.hit,
								" player %h enemy %h last %0b,",
								want.player_id, want.enemy_id, want.last,
								" got status %0d hit %0d player %h enemy %h last %0b",
								got.status, got.hit, got.player_id, got.enemy_id,
								got.last);
						errors++;
					end
				end
			end
			fail_count = errors;
			words_due <= answers_due.size();
		end
	end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives command words into the collision scan unit: a directed opening on
// id, kind and coordinate extremes, then random add, remove, move and tick
// traffic around a moving hot spot, with crowded scenes that fill both tables
// and produce long pair reports. Source gaps and sink stalls change by
// phase. A side checker predicts and compares every answer word.
// ----------------------------------------------------------------------------
module testbench;
	import cscan_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS_TOTAL = 360;
	localparam int ID_POOL     = 24;
	localparam int QUIET_LIMIT = 5000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	int fail_count;
	int words_due;
	int items_sent = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int quiet_cycles = 0;
	int spot_x, spot_y;
	logic [15:0] odd_ids [$];

	int idle_by_phase  [4] = '{0, 47, 0, 26};
	int stall_by_phase [4] = '{0, 0, 47, 26};

	two_group_box_collision_scan_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	cscan_checker u_scan_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.words_due  (words_due)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sink side stalls at the rate of the current phase
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall);
	end

	// give up when no word moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	// present one command word and hold it until accepted
	task automatic send_word(input op_t op, input logic [15:0] id, input logic [2:0] kind,
		input logic [11:0] x, input logic [11:0] y, input logic [7:0] size);
		in_word_t w;
		w.entity_id = id;
		w.kind      = kind;
		w.pos_x     = x;
		w.pos_y     = y;
		w.obj_size  = size;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_DATA_W - $bits(in_word_t)){1'b0}}, w};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// coordinate near a center, now and then anywhere
	function automatic logic [11:0] near(input int centre, input int spread);
		int v;
		if ($urandom_range(15) == 0)
			return 12'($urandom_range(4095));
		v = centre + int'($urandom_range(2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return 12'(v);
	endfunction

	function automatic logic [7:0] pick_size();
		return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(120));
	endfunction

	// id for remove or move: mostly the pool, sometimes odd ones
	function automatic logic [15:0] known_id();
		int r;
		r = $urandom_range(99);
		if (r < 6 && odd_ids.size() != 0)
			return odd_ids[$urandom_range(odd_ids.size() - 1)];
		if (r < 10)
			return 16'($urandom_range(65535));
		return 16'($urandom_range(1, ID_POOL));
	endfunction

	// empty both tables
	task automatic clear_tables();
		for (int i = 1; i <= ID_POOL; i++)
			send_word(OP_REMOVE, 16'(i), 3'($urandom_range(7)), 12'($urandom_range(4095)),
				12'($urandom_range(4095)), 8'($urandom_range(255)));
		foreach (odd_ids[i])
			send_word(OP_REMOVE, odd_ids[i], '0, '0, '0, '0);
		odd_ids.delete();
	endtask

	// fill both tables around one spot so most pairs overlap, then scan
	task automatic crowd_scene();
		clear_tables();
		for (int i = 0; i < 4; i++)
			send_word(OP_ADD, 16'(i + 1), 3'($urandom_range(1, 2)), near(spot_x, 60),
				near(spot_y, 60), 8'($urandom_range(180, 255)));
		for (int i = 0; i < 16; i++)
			send_word(OP_ADD, 16'(i + 5), 3'($urandom_range(3, 7)), near(spot_x, 60),
				near(spot_y, 60), 8'($urandom_range(180, 255)));
		send_word(OP_ADD, 16'd21, 3'($urandom_range(3, 7)), near(spot_x, 60),
			near(spot_y, 60), pick_size());
		send_word(OP_ADD, 16'd22, 3'd1, near(spot_x, 60), near(spot_y, 60), pick_size());
		send_word(OP_TICK, 16'($urandom_range(65535)), 3'($urandom_range(7)),
			12'($urandom_range(4095)), 12'($urandom_range(4095)), 8'($urandom_range(255)));
		// pull one player away and scan again
		send_word(OP_MOVE, 16'd1, 3'($urandom_range(7)), 12'(spot_x ^ 2048),
			12'(spot_y ^ 2048), 8'($urandom_range(255)));
		send_word(OP_TICK, '0, '0, '0, '0, '0);
	endtask

	// one random command
	task automatic random_command();
		int          r;
		logic [15:0] id;
		r = $urandom_range(99);
		if (r < 30) begin
			r = $urandom_range(99);
			if (r < 3) begin
				id = '0;
			end else if (r < 8) begin
				id = 16'($urandom_range(65535));
				odd_ids = {odd_ids, id};
			end else begin
				id = 16'($urandom_range(1, ID_POOL));
			end
			send_word(OP_ADD, id, 3'($urandom_range(7)), near(spot_x, 200),
				near(spot_y, 200), pick_size());
		end else if (r < 50) begin
			send_word(OP_REMOVE, known_id(), 3'($urandom_range(7)),
				12'($urandom_range(4095)), 12'($urandom_range(4095)), 8'($urandom_range(255)));
		end else if (r < 75) begin
			send_word(OP_MOVE, known_id(), 3'($urandom_range(7)), near(spot_x, 200),
				near(spot_y, 200), 8'($urandom_range(255)));
		end else begin
			send_word(OP_TICK, 16'($urandom_range(65535)), 3'($urandom_range(7)),
				12'($urandom_range(4095)), 12'($urandom_range(4095)), 8'($urandom_range(255)));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening: empty scan, refused adds, absent ids
		send_word(OP_TICK, '0, '0, '0, '0, '0);
		send_word(OP_ADD, 16'h0000, 3'd1, 12'd10, 12'd10, 8'd5);
		send_word(OP_ADD, 16'd5, KIND_UNKNOWN, 12'd10, 12'd10, 8'd5);
		send_word(OP_REMOVE, 16'h0000, '0, '0, '0, '0);
		send_word(OP_MOVE, 16'd77, 3'd1, 12'd100, 12'd100, 8'd1);
		// corner objects, size zero touching and size 255 at the limit
		send_word(OP_ADD, 16'hFFFF, 3'd1, 12'd0, 12'd0, 8'd0);
		send_word(OP_ADD, 16'd1, 3'd2, 12'd4095, 12'd4095, 8'd255);
		send_word(OP_ADD, 16'h8000, 3'd7, 12'd0, 12'd0, 8'd0);
		send_word(OP_ADD, 16'hFFFF, 3'd3, 12'd50, 12'd50, 8'd9);
		send_word(OP_ADD, 16'd2, 3'd6, 12'd3840, 12'd4095, 8'd255);
		send_word(OP_TICK, 16'hFFFF, 3'd7, 12'd4095, 12'd4095, 8'd255);
		// one step past the limit, move ignores kind and size
		send_word(OP_MOVE, 16'd2, 3'd0, 12'd3839, 12'd4095, 8'd0);
		send_word(OP_TICK, '0, '0, '0, '0, '0);
		// full player table
		send_word(OP_ADD, 16'd3, 3'd1, 12'd2048, 12'd2048, 8'd128);
		send_word(OP_ADD, 16'd4, 3'd2, 12'd2047, 12'd2049, 8'd127);
		send_word(OP_ADD, 16'd9, 3'd1, 12'd2000, 12'd2000, 8'd1);
		send_word(OP_REMOVE, 16'hFFFF, '0, '0, '0, '0);
		send_word(OP_REMOVE, 16'hFFFF, '0, '0, '0, '0);
		send_word(OP_ADD, 16'd10, 3'd4, 12'd2100, 12'd2000, 8'd60);
		send_word(OP_ADD, 16'd11, 3'd5, 12'd1990, 12'd2040, 8'd3);
		send_word(OP_TICK, '0, '0, '0, '0, '0);
		odd_ids = {odd_ids, 16'h8000};

		// random phases with different gap and stall rates
		for (int ph = 0; ph < 4; ph++) begin
			send_idle  = idle_by_phase[ph];
			recv_stall = stall_by_phase[ph];
			spot_x = $urandom_range(4095);
			spot_y = $urandom_range(4095);
			if (ph % 2 == 0)
				crowd_scene();
			while (items_sent < (ph + 1) * ITEMS_TOTAL / 4)
				random_command();
		end

		// drain and settle
		s_tvalid <= 1'b0;
		recv_stall = 0;
		do @(posedge clk); while (words_due != 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/cscan_pkg.sv
rtl/cscan_ram.sv
rtl/cscan_cmp.sv
rtl/two_group_box_collision_scan_unit.sv
rtl/cscan_chk.sv
bench/cscan_checker.sv
bench/testbench.sv
